// ----- sv/sca_pkg.sv -----
// Shared types and field layout for the schedule cost accumulator.
`default_nettype none

package sca_pkg;

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 496;

  // Packed structs list the highest field first, so the first field sits in the highest bits.
  typedef struct packed {
    logic [7:0]  early_weight;
    logic [7:0]  tardy_weight;
    logic [7:0]  job_weight;
    logic [31:0] release_time;
    logic [31:0] due_date;
    logic [15:0] proc_time;
  } job_t;

  typedef struct packed {
    logic signed [47:0] weighted_flow_sum;
    logic [47:0] weighted_completion_sum;
    logic [47:0] completion_sum;
    logic [31:0] max_earliness;
    logic [47:0] weighted_earliness_sum;
    logic [47:0] earliness_sum;
    logic [31:0] max_tardiness;
    logic [47:0] weighted_tardiness_sum;
    logic [47:0] tardiness_sum;
    logic [31:0] weighted_tardy_count;
    logic [31:0] tardy_count;
    logic [31:0] makespan;
  } cost_t;

  // Word held in the input register, handed to the core.
  typedef struct packed {
    logic start_new;
    job_t job;
  } stage_t;

endpackage

`default_nettype wire

// ----- sv/schedule_cost_accumulator.sv -----
// Top level of the schedule cost accumulator.
//
// Takes one job word per clock while in_tready is high and returns one cost word per job,
// in order. A job passes the input register and then the cost core, where makespan,
// completion time, tardiness or earliness, the three weight products and every aggregate
// are formed combinationally and land in the output register: out_tvalid rises once the
// job has passed the input register and the output register, one job per cycle sustained
// while out_tready holds high. That rate is set by the makespan and accumulator feedback
// in the core. The input side keeps taking words while a result waits on out_tready,
// until both registers are full. tuser bit 0 clears all statistics, makespan included,
// before that job is counted.
`default_nettype none

module schedule_cost_accumulator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // proc_time, due_date, release_time, job_weight, tardy_weight, early_weight
  input  wire logic [sca_pkg::IN_DATA_W-1:0]   in_tdata,
  // start_new
  input  wire logic [0:0]                      in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // makespan, tardy_count, weighted_tardy_count, tardiness_sum, weighted_tardiness_sum,
  // max_tardiness, earliness_sum, weighted_earliness_sum, max_earliness, completion_sum,
  // weighted_completion_sum, weighted_flow_sum
  output logic [sca_pkg::OUT_DATA_W-1:0]       out_tdata
);

  logic            core_ready;
  logic            stg_valid;
  sca_pkg::stage_t stg_word;
  sca_pkg::cost_t  out_cost;

  sca_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_job     (sca_pkg::job_t'(in_tdata)),
    .in_start   (in_tuser[0]),
    .core_ready (core_ready),
    .stg_valid  (stg_valid),
    .stg_word   (stg_word)
  );

  sca_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .stg_valid  (stg_valid),
    .stg_word   (stg_word),
    .core_ready (core_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_cost   (out_cost)
  );

  assign out_tdata = out_cost;

endmodule

`default_nettype wire

// ----- sv/sca_in_stage.sv -----
// Input register stage: captures one job word per cycle while in_tready is high and offers it to the core.
`default_nettype none

module sca_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire sca_pkg::job_t in_job,
  input  wire logic          in_start,
  input  wire logic          core_ready,
  output logic               stg_valid,
  output sca_pkg::stage_t    stg_word
);

  logic            valid_r;
  logic            valid_nxt;
  sca_pkg::stage_t word_r;
  logic            load;

  // Register frees up in the same cycle the core takes its word.
  assign in_tready = !valid_r || core_ready;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (core_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r.start_new <= in_start;
      word_r.job       <= in_job;
    end
  end

  assign stg_valid = valid_r;
  assign stg_word  = word_r;

endmodule

`default_nettype wire

// ----- sv/sca_core.sv -----
// Cost core: makespan and running aggregates, updated per job into the result register.
`default_nettype none

module sca_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            stg_valid,
  input  wire sca_pkg::stage_t stg_word,
  output logic                 core_ready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output sca_pkg::cost_t       out_cost
);

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        adv;

  logic [31:0] ms_r;
  logic [31:0] late_r;
  logic [31:0] lwt_r;
  logic [47:0] tard_r;
  logic [47:0] wtard_r;
  logic [31:0] tpeak_r;
  logic [47:0] early_r;
  logic [47:0] wearly_r;
  logic [31:0] epeak_r;
  logic [47:0] compl_r;
  logic [47:0] wcompl_r;
  logic [47:0] wflow_r;

  sca_pkg::cost_t cost_r;
  sca_pkg::cost_t cost_nxt;

  logic [31:0] b_ms;
  logic [31:0] b_late;
  logic [31:0] b_lwt;
  logic [47:0] b_tard;
  logic [47:0] b_wtard;
  logic [31:0] b_tpeak;
  logic [47:0] b_early;
  logic [47:0] b_wearly;
  logic [31:0] b_epeak;
  logic [47:0] b_compl;
  logic [47:0] b_wcompl;
  logic [47:0] b_wflow;

  logic               clr;
  logic [31:0]        c;
  logic               late;
  logic [31:0]        t;
  logic [31:0]        e;
  logic [39:0]        wt_prod;
  logic [39:0]        we_prod;
  logic [39:0]        wc_prod;
  logic signed [32:0] flow_diff;
  logic signed [41:0] wf_prod;

  assign core_ready = !out_valid_r || out_tready;
  assign adv        = stg_valid && core_ready;

  // A start flag makes this job see cleared statistics.
  assign clr      = stg_word.start_new;
  assign b_ms     = clr ? '0 : ms_r;
  assign b_late   = clr ? '0 : late_r;
  assign b_lwt    = clr ? '0 : lwt_r;
  assign b_tard   = clr ? '0 : tard_r;
  assign b_wtard  = clr ? '0 : wtard_r;
  assign b_tpeak  = clr ? '0 : tpeak_r;
  assign b_early  = clr ? '0 : early_r;
  assign b_wearly = clr ? '0 : wearly_r;
  assign b_epeak  = clr ? '0 : epeak_r;
  assign b_compl  = clr ? '0 : compl_r;
  assign b_wcompl = clr ? '0 : wcompl_r;
  assign b_wflow  = clr ? '0 : wflow_r;

  assign c    = b_ms + {16'd0, stg_word.job.proc_time};
  assign late = c > stg_word.job.due_date;
  assign t    = c - stg_word.job.due_date;
  assign e    = stg_word.job.due_date - c;

  assign wt_prod   = {32'd0, stg_word.job.tardy_weight} * {8'd0, t};
  assign we_prod   = {32'd0, stg_word.job.early_weight} * {8'd0, e};
  assign wc_prod   = {32'd0, stg_word.job.job_weight} * {8'd0, c};
  assign flow_diff = $signed({1'b0, c}) - $signed({1'b0, stg_word.job.release_time});
  // 9-bit signed weight times 33-bit signed difference fits 42 bits
  assign wf_prod   = $signed({{9{flow_diff[32]}}, flow_diff})
                   * $signed({34'd0, stg_word.job.job_weight});

  always_comb begin
    cost_nxt.makespan                = c;
    cost_nxt.tardy_count             = b_late;
    cost_nxt.weighted_tardy_count    = b_lwt;
    cost_nxt.tardiness_sum           = b_tard;
    cost_nxt.weighted_tardiness_sum  = b_wtard;
    cost_nxt.max_tardiness           = b_tpeak;
    cost_nxt.earliness_sum           = b_early;
    cost_nxt.weighted_earliness_sum  = b_wearly;
    cost_nxt.max_earliness           = b_epeak;
    cost_nxt.completion_sum          = b_compl + {16'd0, c};
    cost_nxt.weighted_completion_sum = b_wcompl + {8'd0, wc_prod};
    cost_nxt.weighted_flow_sum       = $signed(b_wflow + {{6{wf_prod[41]}}, wf_prod});
    if (late) begin
      cost_nxt.tardy_count            = b_late + 32'd1;
      cost_nxt.weighted_tardy_count   = b_lwt + {24'd0, stg_word.job.tardy_weight};
      cost_nxt.tardiness_sum          = b_tard + {16'd0, t};
      cost_nxt.weighted_tardiness_sum = b_wtard + {8'd0, wt_prod};
      if (t > b_tpeak) begin
        cost_nxt.max_tardiness = t;
      end
    end else begin
      cost_nxt.earliness_sum          = b_early + {16'd0, e};
      cost_nxt.weighted_earliness_sum = b_wearly + {8'd0, we_prod};
      if (e > b_epeak) begin
        cost_nxt.max_earliness = e;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ms_r        <= '0;
      late_r      <= '0;
      lwt_r       <= '0;
      tard_r      <= '0;
      wtard_r     <= '0;
      tpeak_r     <= '0;
      early_r     <= '0;
      wearly_r    <= '0;
      epeak_r     <= '0;
      compl_r     <= '0;
      wcompl_r    <= '0;
      wflow_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        ms_r     <= cost_nxt.makespan;
        late_r   <= cost_nxt.tardy_count;
        lwt_r    <= cost_nxt.weighted_tardy_count;
        tard_r   <= cost_nxt.tardiness_sum;
        wtard_r  <= cost_nxt.weighted_tardiness_sum;
        tpeak_r  <= cost_nxt.max_tardiness;
        early_r  <= cost_nxt.earliness_sum;
        wearly_r <= cost_nxt.weighted_earliness_sum;
        epeak_r  <= cost_nxt.max_earliness;
        compl_r  <= cost_nxt.completion_sum;
        wcompl_r <= cost_nxt.weighted_completion_sum;
        wflow_r  <= cost_nxt.weighted_flow_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cost_r <= cost_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_cost   = cost_r;

endmodule

`default_nettype wire

// ----- sv/sca_checker.sv -----
// Port-level checks for the schedule cost accumulator, bound to the top level.
`default_nettype none

module sca_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [495:0] out_tdata
);

  sca_pkg::cost_t cost;
  assign cost = sca_pkg::cost_t'(out_tdata);

  // Output channel is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // A stalled word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // Every late job has nonzero tardiness, so a zero peak means no late job yet.
  a_no_tardy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && cost.max_tardiness == 32'd0 |->
      cost.tardy_count == 32'd0 && cost.weighted_tardy_count == 32'd0 &&
      cost.tardiness_sum == 48'd0 && cost.weighted_tardiness_sum == 48'd0)
    else $error("tardiness totals nonzero with zero peak");

  // Zero peak earliness means every earliness term so far was zero.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && cost.max_earliness == 32'd0 |->
      cost.earliness_sum == 48'd0 && cost.weighted_earliness_sum == 48'd0)
    else $error("earliness totals nonzero with zero peak");

endmodule

bind schedule_cost_accumulator sca_checker u_sca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
